// File: rtl/core/mcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Minimum covering window: shared package
// Default sizes, field widths and the transaction format that passes from
// the front end to the back end through the command queue.
// ----------------------------------------------------------------------------
package mcw_pkg;

  localparam int MAX_TEXT = 4096;
  localparam int ALPHABET = 256;
  localparam int SYM_W = 8;
  localparam int NEED_W = 13;
  localparam int unsigned NEED_MAX = 8191;
  localparam int START_W = 12;
  localparam int LEN_W = 13;
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;

  typedef enum logic {
    OP_PATTERN = 1'b0,
    OP_TEXT    = 1'b1
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e          op;
    logic [SYM_W-1:0] sym;
    logic             last;
  } cmd_t;

endpackage
`default_nettype wire

// File: rtl/core/min_covering_window_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Minimum covering window: top level
// Finds the first shortest text window that holds every pattern symbol.
//
// A transaction is taken at a rising edge with start high and busy low.
// command_i low adds symbol_i to the pattern; command_i high appends it to
// the text, and last_i high on a text symbol closes the problem. The result
// is shown for exactly one cycle with done_o high: found_o, start_res_o,
// length_o and overflow_o. The receiver cannot hold it off.
// Transactions pass through a two-entry queue to the execution engine.
// A pattern symbol occupies the engine while its count is read and
// written back. A text symbol is stored, counted and checked, and each
// symbol dropped from the left of the window is read back, uncounted and
// checked again; each symbol is dropped at most once. done_o is registered
// from the state that finishes the last text symbol. busy rises when the
// queue is full. Text beyond the store is ignored and sets overflow_o.
// Reset and each result clear all counts at once through per-symbol valid
// bits, so the block accepts transactions immediately.
// ----------------------------------------------------------------------------
module min_covering_window_top #(
  parameter int MaxText  = mcw_pkg::MAX_TEXT,
  parameter int Alphabet = mcw_pkg::ALPHABET
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        command_i,
  input  wire logic [mcw_pkg::SYM_W-1:0]   symbol_i,
  input  wire logic                        last_i,
  output logic                             done_o,
  output logic                             found_o,
  output logic [mcw_pkg::START_W-1:0]      start_res_o,
  output logic [mcw_pkg::LEN_W-1:0]        length_o,
  output logic                             overflow_o
);

  logic          cmd_valid;
  logic          cmd_pop;
  mcw_pkg::cmd_t cmd;

  mcw_front #(
    .Alphabet (Alphabet)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .command_i   (command_i),
    .symbol_i    (symbol_i),
    .last_i      (last_i),
    .busy        (busy),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  mcw_back #(
    .MaxText  (MaxText),
    .Alphabet (Alphabet)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .done_o      (done_o),
    .found_o     (found_o),
    .start_res_o (start_res_o),
    .length_o    (length_o),
    .overflow_o  (overflow_o)
  );

endmodule
`default_nettype wire

// File: rtl/core/mcw_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Minimum covering window: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mcw_ram #(
  parameter int Width = 8,
  parameter int Depth = 256,
  localparam int AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: rtl/core/mcw_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Minimum covering window: front end
// Accepts input transactions, folds the symbol into the alphabet, classifies
// the transaction and places it in a short command queue for the back end.
// ----------------------------------------------------------------------------
module mcw_front #(
  parameter int Alphabet = mcw_pkg::ALPHABET
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  input  wire logic                       command_i,
  input  wire logic [mcw_pkg::SYM_W-1:0]  symbol_i,
  input  wire logic                       last_i,
  output logic                            busy,
  output logic                            cmd_valid_o,
  output mcw_pkg::cmd_t                   cmd_o,
  input  wire logic                       cmd_pop_i
);

  localparam int CntW = mcw_pkg::QPTR_W + 1;
  localparam int TabSize = 2 ** mcw_pkg::SYM_W;

  logic [mcw_pkg::SYM_W-1:0] fold_tab [TabSize];

  for (genvar g = 0; g < TabSize; g++) begin : g_fold
    localparam int unsigned FoldVal = g % Alphabet;
    assign fold_tab[g] = mcw_pkg::SYM_W'(FoldVal);
  end

  mcw_pkg::cmd_t             entry_q [mcw_pkg::QDEPTH];
  mcw_pkg::cmd_t             push_entry;
  logic [mcw_pkg::QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [mcw_pkg::QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic                       push;
  logic                       pop;

  assign busy        = (cnt_q == CntW'(mcw_pkg::QDEPTH));
  assign push        = start && !busy;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = entry_q[rd_ptr_q];

  always_comb begin
    push_entry.op   = command_i ? mcw_pkg::OP_TEXT : mcw_pkg::OP_PATTERN;
    push_entry.sym  = fold_tab[symbol_i];
    push_entry.last = command_i && last_i;
  end

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + mcw_pkg::QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + mcw_pkg::QPTR_W'(1) : rd_ptr_q;
    unique case ({push, pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_entry;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/mcw_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Minimum covering window: back end
// Executes queued transactions: count updates, text storage, window
// shrinking, best window tracking and the final result.
// ----------------------------------------------------------------------------
module mcw_back #(
  parameter int MaxText  = mcw_pkg::MAX_TEXT,
  parameter int Alphabet = mcw_pkg::ALPHABET
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cmd_valid_i,
  input  wire mcw_pkg::cmd_t                cmd_i,
  output logic                              cmd_pop_o,
  output logic                              done_o,
  output logic                              found_o,
  output logic [mcw_pkg::START_W-1:0]       start_res_o,
  output logic [mcw_pkg::LEN_W-1:0]         length_o,
  output logic                              overflow_o
);

  localparam int PosW    = $clog2(MaxText + 1);
  localparam int StAddrW = $clog2(MaxText);
  localparam int SymW    = $clog2(Alphabet);
  localparam int NeedW   = mcw_pkg::NEED_W;
  localparam int HaveW   = PosW;
  localparam int CntW    = NeedW + HaveW;
  localparam int CmpW    = (NeedW > HaveW) ? NeedW : HaveW;
  localparam int DefW    = $clog2(Alphabet * mcw_pkg::NEED_MAX + 1);
  localparam int StartW  = mcw_pkg::START_W;
  localparam int LenW    = mcw_pkg::LEN_W;

  localparam logic [PosW-1:0]  MaxPos  = PosW'(MaxText);
  localparam logic [NeedW-1:0] NeedMax = NeedW'(mcw_pkg::NEED_MAX);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PAT_WR = 3'd1;
  localparam logic [2:0] S_TXT_WR = 3'd2;
  localparam logic [2:0] S_CHK    = 3'd3;
  localparam logic [2:0] S_SYM    = 3'd4;
  localparam logic [2:0] S_CNT    = 3'd5;

  logic [2:0]          state_q, state_d;
  logic [PosW-1:0]     left_q, left_d;
  logic [PosW-1:0]     right_q, right_d;
  logic [DefW-1:0]     deficit_q, deficit_d;
  logic [PosW-1:0]     best_start_q, best_start_d;
  logic [PosW-1:0]     best_len_q, best_len_d;
  logic                have_best_q, have_best_d;
  logic                ovf_q, ovf_d;
  logic [Alphabet-1:0] cnt_vld_q, cnt_vld_d;
  logic [SymW-1:0]     cur_sym_q, cur_sym_d;
  logic                cur_last_q, cur_last_d;
  logic [SymW-1:0]     drop_sym_q, drop_sym_d;
  logic                done_q, done_d;
  logic                found_q, found_d;
  logic [StartW-1:0]   res_start_q, res_start_d;
  logic [LenW-1:0]     res_len_q, res_len_d;
  logic                res_ovf_q, res_ovf_d;

  logic                cnt_we;
  logic [SymW-1:0]     cnt_waddr;
  logic [CntW-1:0]     cnt_wdata;
  logic [SymW-1:0]     cnt_raddr;
  logic [CntW-1:0]     cnt_rdata;
  logic [CntW-1:0]     cnt_word;
  logic [NeedW-1:0]    need;
  logic [HaveW-1:0]    have;
  logic [CmpW-1:0]     need_c;
  logic [CmpW-1:0]     have_c;
  logic                st_we;
  logic [SymW-1:0]     st_rdata;
  logic [PosW-1:0]     win_len;
  logic                emit;

  assign cnt_waddr = (state_q == S_CNT) ? drop_sym_q : cur_sym_q;
  assign cnt_raddr = (state_q == S_SYM) ? st_rdata : cmd_i.sym[SymW-1:0];
  assign cnt_word  = cnt_vld_q[cnt_waddr] ? cnt_rdata : '0;
  assign need      = cnt_word[CntW-1:HaveW];
  assign have      = cnt_word[HaveW-1:0];
  assign need_c    = CmpW'(need);
  assign have_c    = CmpW'(have);
  assign win_len   = right_q - left_q;

  mcw_ram #(
    .Width (CntW),
    .Depth (Alphabet)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  mcw_ram #(
    .Width (SymW),
    .Depth (MaxText)
  ) u_text_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (right_q[StAddrW-1:0]),
    .wdata_i (cmd_i.sym[SymW-1:0]),
    .raddr_i (left_q[StAddrW-1:0]),
    .rdata_o (st_rdata)
  );

  always_comb begin
    state_d      = state_q;
    left_d       = left_q;
    right_d      = right_q;
    deficit_d    = deficit_q;
    best_start_d = best_start_q;
    best_len_d   = best_len_q;
    have_best_d  = have_best_q;
    ovf_d        = ovf_q;
    cnt_vld_d    = cnt_vld_q;
    cur_sym_d    = cur_sym_q;
    cur_last_d   = cur_last_q;
    drop_sym_d   = drop_sym_q;
    done_d       = 1'b0;
    found_d      = found_q;
    res_start_d  = res_start_q;
    res_len_d    = res_len_q;
    res_ovf_d    = res_ovf_q;
    cmd_pop_o    = 1'b0;
    cnt_we       = 1'b0;
    cnt_wdata    = cnt_word;
    st_we        = 1'b0;
    emit         = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o  = 1'b1;
          cur_sym_d  = cmd_i.sym[SymW-1:0];
          cur_last_d = cmd_i.last;
          if (cmd_i.op == mcw_pkg::OP_PATTERN) begin
            state_d = S_PAT_WR;
          end else if (right_q == MaxPos) begin
            ovf_d = 1'b1;
            emit  = cmd_i.last;
          end else begin
            st_we   = 1'b1;
            state_d = S_TXT_WR;
          end
        end
      end
      S_PAT_WR: begin
        if (need != NeedMax) begin
          if (have_c <= need_c) begin
            deficit_d = deficit_q + DefW'(1);
          end
          cnt_we    = 1'b1;
          cnt_wdata = {need + NeedW'(1), have};
          cnt_vld_d[cur_sym_q] = 1'b1;
        end
        state_d = S_IDLE;
      end
      S_TXT_WR: begin
        if (have_c < need_c) begin
          deficit_d = deficit_q - DefW'(1);
        end
        cnt_we    = 1'b1;
        cnt_wdata = {need, have + HaveW'(1)};
        cnt_vld_d[cur_sym_q] = 1'b1;
        right_d   = right_q + PosW'(1);
        state_d   = S_CHK;
      end
      S_CHK: begin
        if (deficit_q == '0 && left_q < right_q) begin
          if (!have_best_q || win_len < best_len_q) begin
            have_best_d  = 1'b1;
            best_start_d = left_q;
            best_len_d   = win_len;
          end
          state_d = S_SYM;
        end else begin
          emit    = cur_last_q;
          state_d = S_IDLE;
        end
      end
      S_SYM: begin
        drop_sym_d = st_rdata;
        state_d    = S_CNT;
      end
      S_CNT: begin
        if (have_c <= need_c) begin
          deficit_d = deficit_q + DefW'(1);
        end
        cnt_we    = 1'b1;
        cnt_wdata = {need, (have != '0) ? have - HaveW'(1) : have};
        cnt_vld_d[drop_sym_q] = 1'b1;
        left_d    = left_q + PosW'(1);
        state_d   = S_CHK;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (emit) begin
      done_d       = 1'b1;
      found_d      = have_best_q;
      res_start_d  = have_best_q ? StartW'(best_start_q) : '0;
      res_len_d    = have_best_q ? LenW'(best_len_q) : '0;
      res_ovf_d    = ovf_d;
      left_d       = '0;
      right_d      = '0;
      deficit_d    = '0;
      best_start_d = '0;
      best_len_d   = '0;
      have_best_d  = 1'b0;
      ovf_d        = 1'b0;
      cnt_vld_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      left_q      <= '0;
      right_q     <= '0;
      deficit_q   <= '0;
      have_best_q <= 1'b0;
      ovf_q       <= 1'b0;
      cnt_vld_q   <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      left_q      <= left_d;
      right_q     <= right_d;
      deficit_q   <= deficit_d;
      have_best_q <= have_best_d;
      ovf_q       <= ovf_d;
      cnt_vld_q   <= cnt_vld_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_start_q <= best_start_d;
    best_len_q   <= best_len_d;
    cur_sym_q    <= cur_sym_d;
    cur_last_q   <= cur_last_d;
    drop_sym_q   <= drop_sym_d;
    found_q      <= found_d;
    res_start_q  <= res_start_d;
    res_len_q    <= res_len_d;
    res_ovf_q    <= res_ovf_d;
  end

  assign done_o      = done_q;
  assign found_o     = found_q;
  assign start_res_o = res_start_q;
  assign length_o    = res_len_q;
  assign overflow_o  = res_ovf_q;

`ifndef NO_ASSERTIONS
  a_done_in_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == S_IDLE)
    else $error("Result strobe raised while the back end is still working.");

  a_window_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_q <= right_q)
    else $error("Window left edge has passed the right edge.");

  a_text_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    right_q <= MaxPos)
    else $error("Text position has run beyond the store.");

  a_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (right_q == '0 && left_q == '0 && !have_best_q && !ovf_q))
    else $error("Problem state not cleared with the result.");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && !found_q |-> (res_start_q == '0 && res_len_q == '0))
    else $error("Result without a window carries a non-zero position.");
`endif

endmodule
`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Minimum covering window: testbench
// Sends pattern and text symbols through the start/busy handshake and
// predicts every result in a scoreboard that keeps its own symbol counts,
// text store and best window. Each strobed result is compared field by field
// with the oldest prediction. The run covers directed corner cases and
// random problems under three sender idling profiles.
// ----------------------------------------------------------------------------
package mcw_tb_pkg;

  import mcw_pkg::*;

  typedef struct {
    logic               found;
    logic [START_W-1:0] start_res;
    logic [LEN_W-1:0]   length;
    logic               overflow;
  } window_t;

  class window_scoreboard;
    int unsigned need_cnt[ALPHABET];
    int unsigned have_cnt[ALPHABET];
    logic [SYM_W-1:0] text_mem[MAX_TEXT];
    int unsigned left_idx;
    int unsigned right_idx;
    int unsigned missing;
    int unsigned best_start;
    int unsigned best_len;
    bit have_best;
    bit text_overflowed;
    window_t window_q[$];
    int errors;
    int checked;
    int found_seen;
    int overflow_seen;

    function new();
      errors = 0;
      checked = 0;
      found_seen = 0;
      overflow_seen = 0;
      clear();
    endfunction

    function void clear();
      foreach (need_cnt[i]) begin
        need_cnt[i] = 0;
        have_cnt[i] = 0;
      end
      left_idx = 0;
      right_idx = 0;
      missing = 0;
      best_start = 0;
      best_len = 0;
      have_best = 1'b0;
      text_overflowed = 1'b0;
    endfunction

    function int outstanding();
      return window_q.size();
    endfunction

    function void add_text(logic [SYM_W-1:0] sym);
      int unsigned drop;
      if (right_idx >= MAX_TEXT) begin
        text_overflowed = 1'b1;
        return;
      end
      text_mem[right_idx] = sym;
      right_idx++;
      if (have_cnt[sym] < need_cnt[sym]) missing--;
      have_cnt[sym]++;
      while (missing == 0 && left_idx < right_idx) begin
        if (!have_best || (right_idx - left_idx) < best_len) begin
          have_best = 1'b1;
          best_start = left_idx;
          best_len = right_idx - left_idx;
        end
        drop = text_mem[left_idx];
        if (have_cnt[drop] <= need_cnt[drop]) missing++;
        if (have_cnt[drop] > 0) have_cnt[drop]--;
        left_idx++;
      end
    endfunction

    function void note_input(cmd_op_e op, logic [SYM_W-1:0] sym, logic last);
      window_t w;
      if (op == OP_PATTERN) begin
        if (need_cnt[sym] < NEED_MAX) begin
          if (have_cnt[sym] <= need_cnt[sym]) missing++;
          need_cnt[sym]++;
        end
        return;
      end
      add_text(sym);
      if (!last) return;
      w.found = have_best;
      w.start_res = have_best ? START_W'(best_start) : '0;
      w.length = have_best ? LEN_W'(best_len) : '0;
      w.overflow = text_overflowed;
      window_q.push_back(w);
      clear();
    endfunction

    task report(string msg);
      $display("tb: mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic found, logic [START_W-1:0] start_res,
                      logic [LEN_W-1:0] length, logic overflow);
      window_t w;
      if (window_q.size() == 0) begin
        report("result strobed with no transaction awaiting one");
        return;
      end
      w = window_q.pop_front();
      checked++;
      if (found) found_seen++;
      if (overflow) overflow_seen++;
      if (found !== w.found)
        report($sformatf("result %0d: found %b, predicted %b", checked, found, w.found));
      if (start_res !== w.start_res)
        report($sformatf("result %0d: start %0d, predicted %0d", checked, start_res,
                         w.start_res));
      if (length !== w.length)
        report($sformatf("result %0d: length %0d, predicted %0d", checked, length,
                         w.length));
      if (overflow !== w.overflow)
        report($sformatf("result %0d: overflow %b, predicted %b", checked, overflow,
                         w.overflow));
    endtask
  endclass

endpackage

module tb;

  import mcw_pkg::*;
  import mcw_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int PHASE_ITEMS = 250;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               command_i = 1'b0;
  logic [SYM_W-1:0]   symbol_i = '0;
  logic               last_i = 1'b0;
  logic               done_o;
  logic               found_o;
  logic [START_W-1:0] start_res_o;
  logic [LEN_W-1:0]   length_o;
  logic               overflow_o;

  window_scoreboard sb = new();
  int unsigned cycle_cnt = 0;
  int sent = 0;

  min_covering_window_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .command_i   (command_i),
    .symbol_i    (symbol_i),
    .last_i      (last_i),
    .done_o      (done_o),
    .found_o     (found_o),
    .start_res_o (start_res_o),
    .length_o    (length_o),
    .overflow_o  (overflow_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles", cycle_cnt);
      $display("tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(found_o, start_res_o, length_o, overflow_o);
  end

  task automatic send(cmd_op_e op, logic [SYM_W-1:0] sym, logic last, int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    command_i <= op;
    symbol_i <= sym;
    last_i <= last;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_input(op, sym, last);
    sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  task automatic directed_cases(int idle_pct);
    // An empty pattern gives the first symbol as the window.
    send(OP_TEXT, 8'h00, 1'b1, idle_pct);
    send(OP_TEXT, 8'hFF, 1'b0, idle_pct);
    send(OP_TEXT, 8'h00, 1'b0, idle_pct);
    send(OP_TEXT, 8'hFF, 1'b1, idle_pct);
    // No covering window; the last bit on a pattern symbol is ignored.
    send(OP_PATTERN, 8'hFF, 1'b1, idle_pct);
    send(OP_TEXT, 8'h00, 1'b1, idle_pct);
    // Repeated pattern symbols form a multiset.
    send(OP_PATTERN, 8'h61, 1'b0, idle_pct);
    send(OP_PATTERN, 8'h61, 1'b0, idle_pct);
    send(OP_TEXT, 8'h61, 1'b0, idle_pct);
    send(OP_TEXT, 8'h62, 1'b0, idle_pct);
    send(OP_TEXT, 8'h61, 1'b0, idle_pct);
    send(OP_TEXT, 8'h62, 1'b1, idle_pct);
    // A pattern symbol arriving after text has started.
    send(OP_PATTERN, 8'h20, 1'b0, idle_pct);
    send(OP_TEXT, 8'h10, 1'b0, idle_pct);
    send(OP_TEXT, 8'h20, 1'b0, idle_pct);
    send(OP_PATTERN, 8'h10, 1'b0, idle_pct);
    send(OP_TEXT, 8'h20, 1'b0, idle_pct);
    send(OP_TEXT, 8'h10, 1'b1, idle_pct);
  endtask

  task automatic random_problem(int idle_pct);
    logic [SYM_W-1:0] base;
    logic [SYM_W-1:0] sym;
    int span;
    int n_pat;
    int n_txt;
    int i;
    base = SYM_W'($urandom_range(0, 255));
    span = ($urandom_range(0, 7) == 0) ? 255 : $urandom_range(1, 7);
    n_pat = $urandom_range(0, 5);
    n_txt = $urandom_range(1, 40);
    for (i = 0; i < n_pat; i++) begin
      sym = SYM_W'(base + $urandom_range(0, span));
      send(OP_PATTERN, sym, 1'($urandom_range(0, 1)), idle_pct);
    end
    for (i = 0; i < n_txt; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        sym = SYM_W'(base + $urandom_range(0, span));
        send(OP_PATTERN, sym, 1'($urandom_range(0, 1)), idle_pct);
      end
      if ($urandom_range(0, 9) == 0) sym = SYM_W'($urandom_range(0, 255));
      else sym = SYM_W'(base + $urandom_range(0, span));
      send(OP_TEXT, sym, i == n_txt - 1, idle_pct);
    end
  endtask

  task automatic random_phase(int idle_pct);
    int first;
    first = sent;
    while (sent - first < PHASE_ITEMS)
      random_problem(($urandom_range(0, 3) == 0) ? 0 : idle_pct);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_cases(30);
    random_phase(30);
    drain();
    random_phase(62);
    drain();
    random_phase(0);

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.outstanding() != 0)
      sb.report($sformatf("%0d predicted results never arrived", sb.outstanding()));

    $display("tb: %0d transactions accepted, %0d results checked", sent, sb.checked);
    $display("tb: %0d results with a window, %0d with text overflow", sb.found_seen,
             sb.overflow_seen);
    if (sb.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/mcw_pkg.sv
rtl/core/mcw_ram.sv
rtl/core/mcw_front.sv
rtl/core/mcw_back.sv
rtl/core/min_covering_window_top.sv
tb/sv/tb.sv
